### design/assert_macros.svh
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, off during reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked every clock, off during reset
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/smeu_pkg.sv
package smeu_pkg;

  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned NumRegsDef    = 4;
  localparam int unsigned PcWidthDef    = 16;
  localparam int unsigned DataW         = 32;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_SQRT = 5'd4,
    OP_PUSH = 5'd5, OP_PUSHR = 5'd6, OP_POPR = 5'd7, OP_JMP = 5'd8, OP_JB = 5'd9,
    OP_JBE = 5'd10, OP_JA = 5'd11, OP_JAE = 5'd12, OP_JE = 5'd13, OP_JNE = 5'd14,
    OP_IN = 5'd15, OP_OUT = 5'd16, OP_HLT = 5'd17
  } opcode_t;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BADOP  = 3'd1;
  localparam logic [2:0] ST_BADREG = 3'd2;
  localparam logic [2:0] ST_UNDER  = 3'd3;
  localparam logic [2:0] ST_OVER   = 3'd4;
  localparam logic [2:0] ST_DIV0   = 3'd5;

  typedef struct packed {
    logic [4:0]         req_type;
    logic signed [31:0] operand;
    logic [15:0]        pc;
    logic signed [31:0] in_value;
  } req_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic [2:0]         status;
  } rsp_t;

  // iterative unit control
  typedef struct packed {
    logic              start;
    logic              is_sqrt;
    logic [DataW-1:0]  a;
    logic [DataW-1:0]  b;
  } iter_cmd_t;

endpackage

### design/smeu_ram.sv
// Generic RAM with one write port and one read port, registered read
module smeu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/smeu_iter.sv
// Iterative unsigned divide / square root, one bit per cycle
module smeu_iter (
  input  logic                 clk,
  input  logic                 rst,
  input  smeu_pkg::iter_cmd_t  cmd,
  output logic                 done,
  output logic [31:0]          result
);
  logic [31:0] quo;
  logic [32:0] rem;
  logic [31:0] num;
  logic [31:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic        sq;
  logic [33:0] trial;
  logic [33:0] rem_sh;
  logic [32:0] rem_d;

  // one restoring step
  always_comb begin
    rem_sh = '0;
    trial  = '0;
    rem_d  = {rem[31:0], num[31]};
    if (sq) begin
      rem_sh = {rem[31:0], num[31:30]};
      trial  = rem_sh - {quo, 2'b01};
    end else begin
      trial  = {1'b0, rem_d} - {2'b0, den};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // pulse after the last step
      done <= !cmd.start && busy && (cnt == 6'd1);
      if (cmd.start) begin
        busy <= 1'b1;
        sq   <= cmd.is_sqrt;
        num  <= cmd.a;
        den  <= cmd.b;
        rem  <= '0;
        quo  <= '0;
        cnt  <= cmd.is_sqrt ? 6'd16 : 6'd32;
      end else if (busy) begin
        if (sq) begin
          num <= {num[29:0], 2'b00};
          if (!trial[33]) begin
            rem <= trial[32:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rem_sh[32:0];
            quo <= {quo[30:0], 1'b0};
          end
        end else begin
          num <= {num[30:0], 1'b0};
          if (!trial[33]) begin
            rem <= trial[32:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rem_d;
            quo <= {quo[30:0], 1'b0};
          end
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign result = quo;
endmodule

### design/stack_machine_execute_unit.sv
// Sequence from accept to result for most opcodes: two stack reads, operand capture,
// multiply register, write back; DIV and SQRT also wait on the
// one-bit-per-cycle divide / root unit (32 and 16 steps).
// One instruction at a time; the next word is taken the cycle after the result is
// registered. A waiting result stalls write back.
// Reset clears the stack count and register file; no clearing pass.
module stack_machine_execute_unit #(
  parameter int unsigned STACK_DEPTH = smeu_pkg::StackDepthDef,
  parameter int unsigned NUM_REGS    = smeu_pkg::NumRegsDef,
  parameter int unsigned PC_WIDTH    = smeu_pkg::PcWidthDef
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  smeu_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output smeu_pkg::rsp_t  out_data
);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_RD1, S_RD2, S_EXEC, S_MUL, S_ITER, S_DONE} state_t;

  state_t           state;
  smeu_pkg::req_t   req;
  logic [CW-1:0]    cnt;
  logic [31:0]      reg_file [NUM_REGS];
  logic [31:0]      top_v, sec_v;
  logic             und;
  logic [31:0]      prod;
  logic             neg_q;

  // stack memory
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [31:0]      wdata, rdata;

  smeu_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  smeu_pkg::iter_cmd_t icmd;
  logic                idone;
  logic [31:0]         ires;

  smeu_iter u_iter (.clk, .rst, .cmd(icmd), .done(idone), .result(ires));

  smeu_pkg::opcode_t op;
  assign op = smeu_pkg::opcode_t'(req.req_type);

  logic two_pop, one_pop;
  assign two_pop = (op <= smeu_pkg::OP_DIV) ||
                   (op >= smeu_pkg::OP_JB && op <= smeu_pkg::OP_JNE);
  assign one_pop = (op == smeu_pkg::OP_SQRT) || (op == smeu_pkg::OP_POPR) ||
                   (op == smeu_pkg::OP_OUT);

  logic reg_ok;
  assign reg_ok = !req.operand[31] && ($unsigned(req.operand) < 32'(NUM_REGS));
  logic [RW-1:0] ridx;
  assign ridx = req.operand[RW-1:0];

  // pop count actually available
  logic [1:0] npop;
  logic [CW-1:0] cnt_after;
  always_comb begin
    npop = 2'd0;
    if (two_pop) npop = (cnt >= CW'(2)) ? 2'd2 : ((cnt == CW'(1)) ? 2'd1 : 2'd0);
    else if (one_pop && reg_ok | (op != smeu_pkg::OP_POPR))
      npop = (cnt != '0) ? 2'd1 : 2'd0;
    cnt_after = cnt - CW'(npop);
  end

  logic signed [31:0] as, bs;
  assign as = $signed(sec_v);
  assign bs = $signed(top_v);

  logic [PC_WIDTH-1:0] pc1, pc2;
  assign pc1 = PC_WIDTH'(req.pc) + PC_WIDTH'(1);
  assign pc2 = PC_WIDTH'(req.pc) + PC_WIDTH'(2);

  logic [31:0] abs_a, abs_b;
  assign abs_a = sec_v[31] ? 32'd0 - sec_v : sec_v;
  assign abs_b = top_v[31] ? 32'd0 - top_v : top_v;

  // top entry read first, second entry in the following cycle; unit starts once both are held
  always_comb begin
    raddr = AW'(cnt - CW'(1));
    if (state == S_RD2) raddr = AW'(cnt - CW'(2));
    icmd = '0;
    if (state == S_MUL && op == smeu_pkg::OP_DIV && top_v != '0) begin
      icmd.start = 1'b1;
      icmd.a = abs_a;
      icmd.b = abs_b;
    end
    if (state == S_MUL && op == smeu_pkg::OP_SQRT && !top_v[31]) begin
      icmd.start = 1'b1;
      icmd.is_sqrt = 1'b1;
      icmd.a = top_v;
    end
  end

  assign in_ready = (state == S_IDLE);

  // write back only once the output register is free
  logic done_go;
  assign done_go = (state == S_DONE) && (!out_valid || out_ready);

  // sequencer and write back; a push writes at cnt_after
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      we        <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) reg_file[i] <= '0;
    end else begin
      if (done_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          we <= 1'b0;
          if (in_valid && in_ready) begin
            req   <= in_data;
            state <= S_RD1;
          end
        end
        S_RD1: state <= S_RD2;
        S_RD2: begin
          // rdata holds the top entry
          top_v <= (cnt != '0) ? rdata : '0;
          state <= S_EXEC;
        end
        S_EXEC: begin
          // second entry lands now
          sec_v <= (cnt >= CW'(2)) ? rdata : '0;
          und <= (two_pop && cnt < CW'(2)) || (one_pop && cnt == '0);
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= sec_v * top_v;
          neg_q <= sec_v[31] ^ top_v[31];
          state <= ((op == smeu_pkg::OP_DIV && top_v != '0) ||
                    (op == smeu_pkg::OP_SQRT && !top_v[31])) ? S_ITER : S_DONE;
        end
        S_ITER: if (idone) state <= S_DONE;
        S_DONE: if (done_go) begin
          logic [2:0]          st;
          logic [PC_WIDTH-1:0] np;
          logic                push, tk, wr;
          logic [31:0]         pv;
          logic [31:0]         ov;
          logic [CW-1:0]       nc;
          st = smeu_pkg::ST_OK; np = pc1; push = 1'b0; pv = '0; tk = 1'b0; ov = '0;
          if (und) st = smeu_pkg::ST_UNDER;
          priority if (req.req_type > smeu_pkg::OP_HLT) begin
            st = smeu_pkg::ST_BADOP; np = PC_WIDTH'(req.pc);
          end else if ((op == smeu_pkg::OP_PUSHR || op == smeu_pkg::OP_POPR) && !reg_ok) begin
            st = smeu_pkg::ST_BADREG; np = PC_WIDTH'(req.pc);
          end else begin
            unique case (op)
              smeu_pkg::OP_ADD: begin push = 1'b1; pv = sec_v + top_v; end
              smeu_pkg::OP_SUB: begin push = 1'b1; pv = sec_v - top_v; end
              smeu_pkg::OP_MUL: begin push = 1'b1; pv = prod; end
              smeu_pkg::OP_DIV: begin
                push = 1'b1;
                if (top_v == '0) begin
                  pv = '0;
                  if (st == smeu_pkg::ST_OK) st = smeu_pkg::ST_DIV0;
                end else pv = neg_q ? 32'd0 - ires : ires;
              end
              smeu_pkg::OP_SQRT: begin push = 1'b1; pv = top_v[31] ? '0 : ires; end
              smeu_pkg::OP_PUSH: begin push = 1'b1; pv = req.operand; np = pc2; end
              smeu_pkg::OP_PUSHR: begin push = 1'b1; pv = reg_file[ridx]; np = pc2; end
              smeu_pkg::OP_POPR: begin reg_file[ridx] <= top_v; np = pc2; end
              smeu_pkg::OP_IN: begin push = 1'b1; pv = req.in_value; end
              smeu_pkg::OP_OUT: ov = top_v;
              smeu_pkg::OP_HLT: ;
              default: begin
                unique case (op)
                  smeu_pkg::OP_JB:  tk = as < bs;
                  smeu_pkg::OP_JBE: tk = !(bs < as);
                  smeu_pkg::OP_JA:  tk = bs < as;
                  smeu_pkg::OP_JAE: tk = !(as < bs);
                  smeu_pkg::OP_JE:  tk = sec_v == top_v;
                  smeu_pkg::OP_JNE: tk = sec_v != top_v;
                  default:          tk = 1'b1;
                endcase
                np = tk ? PC_WIDTH'(req.operand) : pc2;
              end
            endcase
          end
          nc = cnt_after;
          wr = 1'b0;
          if (push) begin
            if (cnt_after >= CW'(STACK_DEPTH)) begin
              if (st == smeu_pkg::ST_OK) st = smeu_pkg::ST_OVER;
            end else begin
              wr = 1'b1;
              nc = cnt_after + CW'(1);
            end
          end
          cnt   <= nc;
          we    <= wr;
          waddr <= AW'(cnt_after);
          wdata <= pv;
          out_data.next_pc   <= 16'(np);
          out_data.out_valid <= (op == smeu_pkg::OP_OUT);
          out_data.out_value <= ov;
          out_data.status    <= st;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### design/smeu_checker.sv
`include "assert_macros.svh"
// Port-level checks for the execute unit
module smeu_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input smeu_pkg::rsp_t out_data
);
  `CHK_IMPL(a_status_range, clk, rst, out_valid, out_data.status <= smeu_pkg::ST_DIV0, "bad status")
  `CHK_IMPL(a_quiet_value, clk, rst, out_valid && !out_data.out_valid, out_data.out_value == '0, "value without OUT")
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
  `CHK_NEXT(a_one_at_time, clk, rst, in_valid && in_ready, !in_ready, "second word taken")
endmodule

bind stack_machine_execute_unit smeu_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);

### dv/tb_stack_machine_execute_unit.sv
`timescale 1ns / 1ps

module tb_stack_machine_execute_unit;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned REGS     = 4;
  localparam int unsigned LIMIT_CY = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  smeu_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  smeu_pkg::rsp_t out_data;

  stack_machine_execute_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // shadow machine state
  logic [31:0] shadow_stack [DEPTH];
  int unsigned shadow_depth;
  logic [31:0] shadow_regs [REGS];
  logic [2:0]  step_status;

  smeu_pkg::rsp_t expected_rsp [$];
  int   fail_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   cycle_count = 0;

  function automatic void flag_status(input logic [2:0] code);
    if (step_status == smeu_pkg::ST_OK) step_status = code;
  endfunction

  function automatic logic [31:0] stack_pop();
    if (shadow_depth == 0) begin
      flag_status(smeu_pkg::ST_UNDER);
      return 32'd0;
    end
    shadow_depth--;
    return shadow_stack[shadow_depth];
  endfunction

  function automatic void stack_push(input logic [31:0] v);
    if (shadow_depth >= DEPTH) begin
      flag_status(smeu_pkg::ST_OVER);
      return;
    end
    shadow_stack[shadow_depth] = v;
    shadow_depth++;
  endfunction

  function automatic logic [31:0] floor_root(input logic [31:0] v);
    logic [31:0] rem, root, bit_w;
    rem = v;
    root = 0;
    bit_w = 32'h4000_0000;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (rem >= root + bit_w) begin
        rem = rem - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  // Compute the result of one instruction and update the shadow state
  function automatic smeu_pkg::rsp_t execute_instr(input smeu_pkg::req_t rq);
    smeu_pkg::rsp_t r;
    logic signed [31:0] a, b;
    logic [31:0] res;
    logic [15:0] nxt;
    logic take;
    logic reg_ok;
    nxt = rq.pc + 16'd1;
    r = '0;
    take = 1'b0;
    step_status = smeu_pkg::ST_OK;
    reg_ok = (rq.operand >= 0) && (rq.operand < REGS);
    case (rq.req_type)
      smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV: begin
        b = stack_pop();
        a = stack_pop();
        if (rq.req_type == smeu_pkg::OP_ADD) res = a + b;
        else if (rq.req_type == smeu_pkg::OP_SUB) res = a - b;
        else if (rq.req_type == smeu_pkg::OP_MUL) res = a * b;
        else if (b == 0) begin
          res = 0;
          flag_status(smeu_pkg::ST_DIV0);
        end else if (a == 32'sh8000_0000 && b == -32'sd1) res = a;
        else res = a / b;
        stack_push(res);
      end
      smeu_pkg::OP_SQRT: begin
        a = stack_pop();
        stack_push(a[31] ? 32'd0 : floor_root(a));
      end
      smeu_pkg::OP_PUSH: begin
        stack_push(rq.operand);
        nxt = rq.pc + 16'd2;
      end
      smeu_pkg::OP_PUSHR, smeu_pkg::OP_POPR: begin
        if (!reg_ok) begin
          step_status = smeu_pkg::ST_BADREG;
          nxt = rq.pc;
        end else begin
          if (rq.req_type == smeu_pkg::OP_PUSHR) stack_push(shadow_regs[rq.operand]);
          else shadow_regs[rq.operand] = stack_pop();
          nxt = rq.pc + 16'd2;
        end
      end
      smeu_pkg::OP_JMP, smeu_pkg::OP_JB, smeu_pkg::OP_JBE, smeu_pkg::OP_JA,
      smeu_pkg::OP_JAE, smeu_pkg::OP_JE, smeu_pkg::OP_JNE: begin
        if (rq.req_type == smeu_pkg::OP_JMP) begin
          take = 1'b1;
        end else begin
          b = stack_pop();
          a = stack_pop();
          case (rq.req_type)
            smeu_pkg::OP_JB:  take = a < b;
            smeu_pkg::OP_JBE: take = a <= b;
            smeu_pkg::OP_JA:  take = a > b;
            smeu_pkg::OP_JAE: take = a >= b;
            smeu_pkg::OP_JE:  take = a == b;
            default:          take = a != b;
          endcase
        end
        nxt = take ? rq.operand[15:0] : rq.pc + 16'd2;
      end
      smeu_pkg::OP_IN: stack_push(rq.in_value);
      smeu_pkg::OP_OUT: begin
        r.out_value = stack_pop();
        r.out_valid = 1'b1;
      end
      smeu_pkg::OP_HLT: ;
      default: begin
        step_status = smeu_pkg::ST_BADOP;
        nxt = rq.pc;
      end
    endcase
    r.next_pc = nxt;
    r.status = step_status;
    return r;
  endfunction

  // Send one word, holding valid until accepted; valid drops only while idling
  task automatic send_instr(input smeu_pkg::req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_rsp.push_back(execute_instr(rq));
    @(negedge clk);
  endtask

  task automatic send_op(input smeu_pkg::opcode_t op, input logic [31:0] opnd,
                         input logic [31:0] inv);
    smeu_pkg::req_t rq;
    rq.req_type = op;
    rq.operand = opnd;
    rq.pc = 16'($urandom);
    rq.in_value = inv;
    send_instr(rq);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Receiver stalls at random
  always @(negedge clk) begin
    if (!rst) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    smeu_pkg::rsp_t exp_r;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_rsp.size() == 0) begin
        $error("result word with nothing expected: %p", out_data);
        fail_count++;
      end else begin
        exp_r = expected_rsp.pop_front();
        if (out_data.next_pc !== exp_r.next_pc) begin
          $error("next_pc exp %h got %h", exp_r.next_pc, out_data.next_pc);
          fail_count++;
        end
        if (out_data.out_valid !== exp_r.out_valid) begin
          $error("out_valid exp %b got %b", exp_r.out_valid, out_data.out_valid);
          fail_count++;
        end
        if (out_data.out_value !== exp_r.out_value) begin
          $error("out_value exp %h got %h", exp_r.out_value, out_data.out_value);
          fail_count++;
        end
        if (out_data.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycle_count > LIMIT_CY) begin
      $display("status: fail");
      $finish;
    end
  end

  // Edge cases: extremes, every opcode except JB, JBE, JA, JAE and JNE, underflow, overflow, div by zero
  task automatic test_directed();
    smeu_pkg::req_t rq;
    send_op(smeu_pkg::OP_ADD, 0, 0);                       // pop from empty stack
    send_op(smeu_pkg::OP_OUT, 0, 0);
    send_op(smeu_pkg::OP_IN, 0, 32'h8000_0000);
    send_op(smeu_pkg::OP_PUSH, 32'hFFFF_FFFF, 0);
    send_op(smeu_pkg::OP_DIV, 0, 0);                       // most negative / -1
    send_op(smeu_pkg::OP_PUSH, 32'h7FFF_FFFF, 0);
    send_op(smeu_pkg::OP_PUSH, 0, 0);
    send_op(smeu_pkg::OP_DIV, 0, 0);                       // divide by zero
    send_op(smeu_pkg::OP_PUSH, 32'h7FFF_FFFF, 0);
    send_op(smeu_pkg::OP_SQRT, 0, 0);
    send_op(smeu_pkg::OP_PUSH, -5, 0);
    send_op(smeu_pkg::OP_SQRT, 0, 0);                      // negative root
    send_op(smeu_pkg::OP_MUL, 0, 0);
    send_op(smeu_pkg::OP_SUB, 0, 0);
    send_op(smeu_pkg::OP_POPR, 3, 0);
    send_op(smeu_pkg::OP_PUSHR, 3, 0);
    send_op(smeu_pkg::OP_PUSHR, 4, 0);                     // bad register
    send_op(smeu_pkg::OP_POPR, 32'h8000_0000, 0);
    send_op(smeu_pkg::OP_JMP, 32'hFFFF_ABCD, 0);
    send_op(smeu_pkg::OP_JE, 7, 0);
    send_op(smeu_pkg::OP_HLT, 0, 0);
    rq = '0;
    rq.req_type = 5'd31;                                   // invalid opcode
    rq.pc = 16'hFFFF;
    send_instr(rq);
    rq.req_type = 5'd18;
    rq.pc = 16'h0000;
    send_instr(rq);
    // fill past the top for overflow
    repeat (DEPTH + 2) send_op(smeu_pkg::OP_IN, $urandom, 0);
    send_op(smeu_pkg::OP_SQRT, 0, 0);
    wait_drained();
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom_range(7);
      1: return -$urandom_range(7);
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random instruction mix, weighted toward well-formed programs
  task automatic test_random(input int n_instr);
    smeu_pkg::req_t rq;
    int   pick;
    for (int i = 0; i < n_instr; i++) begin
      pick = $urandom_range(99);
      rq.pc = 16'($urandom);
      rq.in_value = rand_value();
      rq.operand = rand_value();
      if (pick < 30) begin
        rq.req_type = ($urandom_range(1)) ? smeu_pkg::OP_PUSH : smeu_pkg::OP_IN;
      end else if (pick < 55) begin
        rq.req_type = 5'($urandom_range(smeu_pkg::OP_ADD, smeu_pkg::OP_SQRT));
      end else if (pick < 68) begin
        rq.req_type = ($urandom_range(1)) ? smeu_pkg::OP_PUSHR : smeu_pkg::OP_POPR;
        if ($urandom_range(9) != 0) rq.operand = $urandom_range(REGS - 1);
      end else if (pick < 85) begin
        rq.req_type = 5'($urandom_range(smeu_pkg::OP_JMP, smeu_pkg::OP_JNE));
      end else if (pick < 94) begin
        rq.req_type = smeu_pkg::OP_OUT;
      end else if (pick < 97) begin
        rq.req_type = smeu_pkg::OP_HLT;
      end else begin
        rq.req_type = 5'($urandom_range(int'(smeu_pkg::OP_HLT) + 1, 31));
      end
      send_instr(rq);
    end
  endtask

  // Sender holds off until all results are back, then resumes
  task automatic test_pause();
    test_random(20);
    wait_drained();
    test_random(20);
  endtask

  initial begin
    for (int i = 0; i < REGS; i++) shadow_regs[i] = '0;
    shadow_depth = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    send_idle_pct = 6;
    recv_idle_pct = 82;
    test_random(450);
    test_pause();
    send_idle_pct = 82;
    recv_idle_pct = 6;
    test_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(700);

    wait_drained();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
